@@ design/tfir_pkg.sv @@
// ----------------------------------------------------------------------------
// tfir_pkg
// Shared types, sizes and codes of the tent filter image resampler.
// ----------------------------------------------------------------------------
package tfir_pkg;

	// store geometry and filter reach
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 16;

	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int IDX_W  = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);

	// radius in Q.8, capped
	localparam int RMAX = MAX_RADIUS * 256;
	localparam int R_W  = $clog2(RMAX + 1);
	localparam int R2_W = 2 * R_W;

	// taps per axis
	localparam int TAPS = 2 * MAX_RADIUS + 1;
	localparam int T_W  = $clog2(TAPS);

	// weights Q1.16 (up to 1.0), sums, products
	localparam int W_W   = 17;
	localparam int SUM_W = W_W + T_W;
	localparam int DEN_W = 2 * SUM_W;
	localparam int WXY_W = 2 * W_W;
	localparam int PRD_W = WXY_W + 8;
	localparam int ACC_W = DEN_W + 8;

	// centre, signed Q16.8
	localparam int Q_W = 25;
	localparam int C_W = Q_W + 1;

	// shared divider
	localparam int NUM_W  = ACC_W + 1;
	localparam int STEP_W = $clog2(Q_W + 1);
	localparam logic [STEP_W-1:0] RAD_STEPS = STEP_W'(13);
	localparam logic [STEP_W-1:0] CEN_STEPS = STEP_W'(25);
	localparam logic [STEP_W-1:0] WT_STEPS  = STEP_W'(17);
	localparam logic [STEP_W-1:0] CH_STEPS  = STEP_W'(9);

	localparam logic [12:0] SCALE_MIN = 13'd16;
	localparam logic [12:0] SCALE_MAX = 13'd4096;
	localparam logic [12:0] SCALE_ONE = 13'd256;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_REQ  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_LOADED   = 2'd0,
		STAT_COMPUTED = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_ZERO     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_SCALE_X    = 2'd0,
		REG_SCALE_Y    = 2'd1,
		REG_SRC_WIDTH  = 2'd2,
		REG_SRC_HEIGHT = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_ACCEPT,
		DP_DIV_RX, DP_SET_RX, DP_DIV_RY, DP_SET_RY,
		DP_DIV_CX, DP_SET_CX, DP_DIV_CY, DP_SET_CY,
		DP_WINDOW, DP_DIV_WX, DP_SET_WX, DP_Y_INIT,
		DP_DIV_WY, DP_SET_WY, DP_TAP, DP_NEXT_ROW,
		DP_DEN, DP_DIV_CH, DP_SET_CH, DP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RANGE, ST_RX_W, ST_RY, ST_RY_W, ST_CX, ST_CX_W,
		ST_CY, ST_CY_W, ST_WIN, ST_WCHK, ST_WX, ST_WX_W, ST_YINIT,
		ST_WY, ST_WY_W, ST_TAP, ST_NROW, ST_DRAIN, ST_CH, ST_CH_W, ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic range_bad;
		logic win_empty;
		logic x_last;
		logic y_last;
		logic pipe_busy;
		logic sum_zero;
		logic ch_last;
	} dp_stat_t;

	typedef struct packed {
		logic        opcode;
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [12:0] data;
	} cfg_wr_t;

endpackage

@@ design/tfir_in_if.sv @@
// ----------------------------------------------------------------------------
// tfir_in_if
// Input channel: load and request words.
// ----------------------------------------------------------------------------
interface tfir_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [11:0] row;
	logic [11:0] col;
	logic [7:0]  in_red;
	logic [7:0]  in_green;
	logic [7:0]  in_blue;
	logic [7:0]  in_alpha;

	modport source (output valid, opcode, row, col, in_red, in_green, in_blue, in_alpha,
		input ready);
	modport sink (input valid, opcode, row, col, in_red, in_green, in_blue, in_alpha,
		output ready);
endinterface

@@ design/tfir_out_if.sv @@
// ----------------------------------------------------------------------------
// tfir_out_if
// Output channel: one result word per input word.
// ----------------------------------------------------------------------------
interface tfir_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic [1:0] status;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, status,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, status,
		output ready);
endinterface

@@ design/tfir_cfg_if.sv @@
// ----------------------------------------------------------------------------
// tfir_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tfir_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/tfir_div.sv @@
// ----------------------------------------------------------------------------
// tfir_div
// Shared restoring divider, one quotient bit per cycle, quotient size per job.
// ----------------------------------------------------------------------------
module tfir_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tfir_pkg::NUM_W-1:0]    num,
	input  logic [tfir_pkg::DEN_W-1:0]    den,
	input  logic [tfir_pkg::STEP_W-1:0]   steps,
	output logic                          busy,
	output logic [tfir_pkg::Q_W-1:0]      quot
);
	import tfir_pkg::*;

	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic [Q_W-1:0]    quot_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	// quotient bound keeps the preloaded remainder below the divisor
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DEN_W'(num >> steps);
			num_q  <= num << (NUM_W - 32'(steps));
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q  <= num_q << 1;
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

@@ design/tfir_dp.sv @@
// ----------------------------------------------------------------------------
// tfir_dp
// Datapath: registers, image store, weight table, tap pipeline, divider.
// ----------------------------------------------------------------------------
module tfir_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfir_pkg::dp_cmd_t    cmd,
	input  tfir_pkg::in_word_t   in_word,
	input  tfir_pkg::cfg_wr_t    cfg_wr,
	output tfir_pkg::dp_stat_t   stat,
	output tfir_pkg::out_word_t  out_word
);
	import tfir_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic             empty;
	} win_t;

	function automatic win_t win_f(input logic signed [C_W-1:0] c,
		input logic [R_W-1:0] r, input logic [8:0] n);
		logic signed [C_W:0] ce, re, lo, hi, top;
		win_t w;
		ce  = {c[C_W-1], c};
		re  = $signed((C_W+1)'(r));
		lo  = (ce - re + $signed((C_W+1)'(255))) >>> 8;
		hi  = (ce + re) >>> 8;
		top = $signed((C_W+1)'(n)) - $signed((C_W+1)'(1));
		if (lo < 0)
			lo = '0;
		if (hi > top)
			hi = top;
		w.empty = hi < lo;
		w.lo    = lo[IDX_W-1:0];
		w.hi    = hi[IDX_W-1:0];
		return w;
	endfunction

	// tent weight numerator: ((r-d)<<24) + r*r/2, zero outside the radius
	function automatic logic [NUM_W-1:0] wnum_f(input logic [IDX_W-1:0] idx,
		input logic signed [C_W-1:0] c, input logic [R_W-1:0] r,
		input logic [R2_W-1:0] r2);
		logic signed [C_W:0] pos, diff;
		logic [C_W:0]        ad;
		logic [R_W-1:0]      rd;
		pos  = $signed((C_W+1)'({idx, 8'b0}));
		diff = pos - {c[C_W-1], c};
		ad   = (diff < 0) ? (C_W+1)'(-diff) : (C_W+1)'(diff);
		rd   = r - ad[R_W-1:0];
		if (ad >= (C_W+1)'(r))
			return '0;
		return (NUM_W'(rd) << 24) + NUM_W'(r2 >> 1);
	endfunction

	// configuration
	logic [12:0] scale_x_q, scale_y_q;
	logic [8:0]  src_w_q, src_h_q;
	logic [12:0] sx, sy;
	logic [8:0]  wc, hc;

	// request
	logic [11:0]            row_q, col_q;
	logic [21:0]            outw_q, outh_q;
	logic [R_W-1:0]         rx_q, ry_q;
	logic [R2_W-1:0]        r2x_q, r2y_q;
	logic signed [C_W-1:0]  cx_q, cy_q;
	logic [IDX_W-1:0]       xlo_q, xhi_q, ylo_q, yhi_q;
	logic                   empty_q;
	logic [IDX_W-1:0]       i_q, j_q;
	logic [T_W-1:0]         t_q;
	logic [SUM_W-1:0]       sumx_q, sumy_q;
	logic [W_W-1:0]         wy_q;
	logic [DEN_W-1:0]       den_q;
	logic [1:0]             ch_q;
	logic [7:0]             color_q [4];
	logic [ACC_W-1:0]       acc_q [4];
	out_word_t              out_q;
	win_t                   wx_n, wy_n;

	// stores
	logic [31:0]    img_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [W_W-1:0] wx_mem [TAPS];
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              wr_en;

	// tap pipeline
	logic              v_s1, v_s2, v_s3;
	logic [31:0]       p_s1, p_s2;
	logic [W_W-1:0]    wx_s1;
	logic [WXY_W-1:0]  wxy_s2;
	logic [PRD_W-1:0]  prod_s3 [4];

	// divider
	logic              div_start, div_busy;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [STEP_W-1:0] div_steps;
	logic [Q_W-1:0]    quot;
	logic [R_W-1:0]    rq;
	logic [8:0]        cq;

	always_comb begin
		sx = (scale_x_q < SCALE_MIN) ? SCALE_MIN :
			((scale_x_q > SCALE_MAX) ? SCALE_MAX : scale_x_q);
		sy = (scale_y_q < SCALE_MIN) ? SCALE_MIN :
			((scale_y_q > SCALE_MAX) ? SCALE_MAX : scale_y_q);
		wc = (32'(src_w_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : src_w_q;
		hc = (32'(src_h_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : src_h_q;
		wx_n = win_f(cx_q, rx_q, wc);
		wy_n = win_f(cy_q, ry_q, hc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_ONE;
			scale_y_q <= SCALE_ONE;
			src_w_q   <= 9'd256;
			src_h_q   <= 9'd256;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				REG_SCALE_X:    scale_x_q <= cfg_wr.data;
				REG_SCALE_Y:    scale_y_q <= cfg_wr.data;
				REG_SRC_WIDTH:  src_w_q   <= cfg_wr.data[8:0];
				REG_SRC_HEIGHT: src_h_q   <= cfg_wr.data[8:0];
				default: ;
			endcase
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b1;
		div_num   = '0;
		div_den   = '0;
		div_steps = WT_STEPS;
		case (cmd.op)
			DP_DIV_RX: begin
				div_num = NUM_W'(17'h10000 + 17'(sx >> 1));
				div_den = DEN_W'(sx);
				div_steps = RAD_STEPS;
			end
			DP_DIV_RY: begin
				div_num = NUM_W'(17'h10000 + 17'(sy >> 1));
				div_den = DEN_W'(sy);
				div_steps = RAD_STEPS;
			end
			DP_DIV_CX: begin
				div_num = NUM_W'({col_q, 1'b1, 16'b0}) + NUM_W'(sx);
				div_den = DEN_W'({sx, 1'b0});
				div_steps = CEN_STEPS;
			end
			DP_DIV_CY: begin
				div_num = NUM_W'({row_q, 1'b1, 16'b0}) + NUM_W'(sy);
				div_den = DEN_W'({sy, 1'b0});
				div_steps = CEN_STEPS;
			end
			DP_DIV_WX: begin
				div_num = wnum_f(i_q, cx_q, rx_q, r2x_q);
				div_den = DEN_W'(r2x_q);
			end
			DP_DIV_WY: begin
				div_num = wnum_f(j_q, cy_q, ry_q, r2y_q);
				div_den = DEN_W'(r2y_q);
			end
			DP_DIV_CH: begin
				div_num = NUM_W'(acc_q[ch_q]) + NUM_W'(den_q >> 1);
				div_den = den_q;
				div_steps = CH_STEPS;
			end
			default: div_start = 1'b0;
		endcase
	end

	tfir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign rq = (quot > Q_W'(RMAX)) ? R_W'(RMAX) : quot[R_W-1:0];
	assign cq = (quot > Q_W'(255)) ? 9'd255 : quot[8:0];

	// image store
	assign wr_en   = (cmd.op == DP_ACCEPT) && (in_word.opcode == OP_LOAD) &&
		(32'(in_word.row) < MAX_HEIGHT) && (32'(in_word.col) < MAX_WIDTH);
	assign wr_addr = ADDR_W'(ADDR_W'(in_word.row) * ADDR_W'(MAX_WIDTH)) +
		ADDR_W'(in_word.col);
	assign rd_addr = ADDR_W'(ADDR_W'(j_q) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(i_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			img_mem[wr_addr] <= {in_word.alpha, in_word.blue, in_word.green, in_word.red};
		p_s1 <= img_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_SET_WX)
			wx_mem[t_q] <= quot[W_W-1:0];
		wx_s1 <= wx_mem[t_q];
	end

	// request registers
	always_ff @(posedge clk) begin
		outw_q <= 22'(wc) * 22'(sx);
		outh_q <= 22'(hc) * 22'(sy);
		case (cmd.op)
			DP_ACCEPT: begin
				row_q <= in_word.row;
				col_q <= in_word.col;
			end
			DP_SET_RX: rx_q <= (sx < SCALE_ONE) ? rq : R_W'(256);
			DP_SET_RY: ry_q <= (sy < SCALE_ONE) ? rq : R_W'(256);
			DP_SET_CX: cx_q <= $signed({1'b0, quot}) - $signed(C_W'(128));
			DP_SET_CY: cy_q <= $signed({1'b0, quot}) - $signed(C_W'(128));
			DP_WINDOW: begin
				xlo_q   <= wx_n.lo;
				xhi_q   <= wx_n.hi;
				ylo_q   <= wy_n.lo;
				yhi_q   <= wy_n.hi;
				empty_q <= wx_n.empty | wy_n.empty;
				r2x_q   <= R2_W'(rx_q) * R2_W'(rx_q);
				r2y_q   <= R2_W'(ry_q) * R2_W'(ry_q);
				i_q     <= wx_n.lo;
				t_q     <= '0;
				sumx_q  <= '0;
			end
			DP_SET_WX: begin
				sumx_q <= sumx_q + SUM_W'(quot[W_W-1:0]);
				i_q    <= i_q + IDX_W'(1);
				t_q    <= t_q + T_W'(1);
			end
			DP_Y_INIT: begin
				j_q    <= ylo_q;
				sumy_q <= '0;
			end
			DP_SET_WY: begin
				wy_q   <= quot[W_W-1:0];
				sumy_q <= sumy_q + SUM_W'(quot[W_W-1:0]);
				i_q    <= xlo_q;
				t_q    <= '0;
			end
			DP_TAP: begin
				i_q <= i_q + IDX_W'(1);
				t_q <= t_q + T_W'(1);
			end
			DP_NEXT_ROW: j_q <= j_q + IDX_W'(1);
			DP_DEN: begin
				den_q <= DEN_W'(sumx_q) * DEN_W'(sumy_q);
				ch_q  <= '0;
			end
			DP_SET_CH: begin
				color_q[ch_q] <= cq[7:0];
				ch_q          <= ch_q + 2'd1;
			end
			DP_FINISH: begin
				out_q.status <= cmd.code;
				if (cmd.code == STAT_COMPUTED) begin
					out_q.red   <= color_q[0];
					out_q.green <= color_q[1];
					out_q.blue  <= color_q[2];
					out_q.alpha <= color_q[3];
				end else begin
					out_q.red   <= '0;
					out_q.green <= '0;
					out_q.blue  <= '0;
					out_q.alpha <= '0;
				end
			end
			default: ;
		endcase
	end

	// tap pipeline: read, weight product, channel products, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.op == DP_TAP;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		wxy_s2 <= WXY_W'(wy_q) * WXY_W'(wx_s1);
		p_s2   <= p_s1;
		for (int k = 0; k < 4; k++) begin
			prod_s3[k] <= PRD_W'(wxy_s2) * PRD_W'(p_s2[8*k +: 8]);
			if (cmd.op == DP_Y_INIT)
				acc_q[k] <= '0;
			else if (v_s3)
				acc_q[k] <= acc_q[k] + ACC_W'(prod_s3[k]);
		end
	end

	always_comb begin
		stat.div_busy  = div_busy;
		stat.range_bad = (14'(col_q) >= outw_q[21:8]) || (14'(row_q) >= outh_q[21:8]);
		stat.win_empty = empty_q;
		stat.x_last    = i_q == xhi_q;
		stat.y_last    = j_q == yhi_q;
		stat.pipe_busy = v_s1 | v_s2 | v_s3;
		stat.sum_zero  = (sumx_q == '0) || (sumy_q == '0);
		stat.ch_last   = ch_q == 2'd3;
	end

	assign out_word = out_q;

endmodule

@@ design/tfir_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfir_ctrl
// Sequencer: walks one request through range check, divides, weights and taps.
// ----------------------------------------------------------------------------
module tfir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  tfir_pkg::dp_stat_t  stat,
	output tfir_pkg::dp_cmd_t   cmd
);
	import tfir_pkg::*;

	ctl_state_t state_q, state_d;
	status_t    fin_q, fin_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= STAT_LOADED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			if (cmd.op == DP_FINISH)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		fin_d    = fin_q;
		cmd.op   = DP_NOP;
		cmd.code = fin_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_ACCEPT;
					fin_d   = STAT_LOADED;
					state_d = (in_op == OP_REQ) ? ST_RANGE : ST_FINISH;
				end
			end
			ST_RANGE: begin
				if (stat.range_bad) begin
					fin_d   = STAT_RANGE;
					state_d = ST_FINISH;
				end else begin
					cmd.op  = DP_DIV_RX;
					state_d = ST_RX_W;
				end
			end
			ST_RX_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_RX;
				state_d = ST_RY;
			end
			ST_RY: begin
				cmd.op  = DP_DIV_RY;
				state_d = ST_RY_W;
			end
			ST_RY_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_RY;
				state_d = ST_CX;
			end
			ST_CX: begin
				cmd.op  = DP_DIV_CX;
				state_d = ST_CX_W;
			end
			ST_CX_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_CX;
				state_d = ST_CY;
			end
			ST_CY: begin
				cmd.op  = DP_DIV_CY;
				state_d = ST_CY_W;
			end
			ST_CY_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_CY;
				state_d = ST_WIN;
			end
			ST_WIN: begin
				cmd.op  = DP_WINDOW;
				state_d = ST_WCHK;
			end
			ST_WCHK: begin
				if (stat.win_empty) begin
					fin_d   = STAT_ZERO;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_WX;
				end
			end
			ST_WX: begin
				cmd.op  = DP_DIV_WX;
				state_d = ST_WX_W;
			end
			ST_WX_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_WX;
				state_d = stat.x_last ? ST_YINIT : ST_WX;
			end
			ST_YINIT: begin
				cmd.op  = DP_Y_INIT;
				state_d = ST_WY;
			end
			ST_WY: begin
				cmd.op  = DP_DIV_WY;
				state_d = ST_WY_W;
			end
			ST_WY_W: if (!stat.div_busy) begin
				cmd.op  = DP_SET_WY;
				state_d = ST_TAP;
			end
			ST_TAP: begin
				cmd.op = DP_TAP;
				if (stat.x_last)
					state_d = stat.y_last ? ST_DRAIN : ST_NROW;
			end
			ST_NROW: begin
				cmd.op  = DP_NEXT_ROW;
				state_d = ST_WY;
			end
			ST_DRAIN: if (!stat.pipe_busy) begin
				if (stat.sum_zero) begin
					fin_d   = STAT_ZERO;
					state_d = ST_FINISH;
				end else begin
					cmd.op  = DP_DEN;
					state_d = ST_CH;
				end
			end
			ST_CH: begin
				cmd.op  = DP_DIV_CH;
				state_d = ST_CH_W;
			end
			ST_CH_W: if (!stat.div_busy) begin
				cmd.op = DP_SET_CH;
				if (stat.ch_last) begin
					fin_d   = STAT_COMPUTED;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_CH;
				end
			end
			ST_FINISH: if (!out_valid_q || out_ready) begin
				cmd.op  = DP_FINISH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	// result register is never overwritten while its word is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_FINISH |-> (!out_valid_q || out_ready))
		else $error("result overwritten");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_DIV_RX || cmd.op == DP_DIV_RY || cmd.op == DP_DIV_CX ||
		 cmd.op == DP_DIV_CY || cmd.op == DP_DIV_WX || cmd.op == DP_DIV_WY ||
		 cmd.op == DP_DIV_CH) |-> !stat.div_busy)
		else $error("divider started while busy");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_DEN |-> !stat.pipe_busy)
		else $error("normalize before taps drained");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_FINISH |=> out_valid_q)
		else $error("finished word not presented");

endmodule

@@ design/tent_filter_image_resampler_core.sv @@
// ----------------------------------------------------------------------------
// tent_filter_image_resampler_core
// Tent filter resampler: RGBA8 image store plus one-pixel-at-a-time scaler.
// ----------------------------------------------------------------------------
// Load word: written to the image store if in range; its result word goes out
//   through the finish state and the result register once the last result is taken.
// Request word: time grows with nx, ny = taps per axis (up to 33 each); the shared
//   1-bit-per-cycle divider and the one-tap-per-cycle walk over the image store set it.
// One word in flight; the next word is taken while the last result waits.
// Reset (arst_n low) clears the sequencer and loads the default registers
//   (scale 1.0, 256 x 256); the image store is not cleared.
module tent_filter_image_resampler_core (
	input logic         clk,
	input logic         arst_n,
	tfir_in_if.sink     in_ch,
	tfir_out_if.source  out_ch,
	tfir_cfg_if.sink    cfg
);
	import tfir_pkg::*;

	in_word_t  in_word;
	out_word_t out_word;
	cfg_wr_t   cfg_wr;
	dp_cmd_t   cmd;
	dp_stat_t  stat;

	// register writes land at once
	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	assign in_word.opcode = in_ch.opcode;
	assign in_word.row    = in_ch.row;
	assign in_word.col    = in_ch.col;
	assign in_word.red    = in_ch.in_red;
	assign in_word.green  = in_ch.in_green;
	assign in_word.blue   = in_ch.in_blue;
	assign in_word.alpha  = in_ch.in_alpha;

	// sequencer: owns the input and output handshakes and the per-word schedule
	tfir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: store, divider, weights, tap pipeline, result register
	tfir_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_word),
		.cfg_wr   (cfg_wr),
		.stat     (stat),
		.out_word (out_word)
	);

	assign out_ch.out_red   = out_word.red;
	assign out_ch.out_green = out_word.green;
	assign out_ch.out_blue  = out_word.blue;
	assign out_ch.out_alpha = out_word.alpha;
	assign out_ch.status    = out_word.status;

endmodule

@@ tb/tfir_tb_if.sv @@
// ----------------------------------------------------------------------------
// tfir_tb_if
// Testbench-side note: the channel interfaces come from the design folder.
// This file holds the expected result word type that the checker uses.
// ----------------------------------------------------------------------------
package tfir_tb_pkg;
	import tfir_pkg::*;

	// one expected result word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		status_t    status;
	} pix_result_t;
endpackage

@@ tb/tfir_checker.sv @@
// ----------------------------------------------------------------------------
// tfir_checker
// Watches the load/request, result and register channels, predicts each
// result word from a private copy of the registers and image store, and
// compares field by field.
// ----------------------------------------------------------------------------
module tfir_checker
	import tfir_pkg::*;
	import tfir_tb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tfir_in_if         in_ch,
	tfir_out_if        out_ch,
	tfir_cfg_if        cfg,
	output int         errors,
	output int         pending,
	output int         n_results,
	output int         n_computed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] pix_mem [int];
	logic [12:0] sc_x, sc_y;
	logic [8:0]  img_w, img_h;
	pix_result_t expected_q[$];

	function automatic longint fdiv256(longint a);
		if (a >= 0)
			return a / 256;
		return -((-a + 255) / 256);
	endfunction

	function automatic longint rad_q8(longint s);
		longint r;
		r = 256;
		if (s < 256)
			r = (65536 + s / 2) / s;
		if (r > MAX_RADIUS * 256)
			r = MAX_RADIUS * 256;
		return r;
	endfunction

	function automatic longint ctr_q8(longint k, longint s);
		return ((2 * k + 1) * 65536 + s) / (2 * s) - 128;
	endfunction

	function automatic longint tent_wt(longint d, longint r);
		longint den;
		if (d < 0)
			d = -d;
		if (d >= r)
			return 0;
		den = r * r;
		return (((r - d) << 24) + den / 2) / den;
	endfunction

	function automatic pix_result_t resample(logic [11:0] row, logic [11:0] col);
		pix_result_t res;
		longint sx, sy, w, h, rx, ry, cx, cy, xlo, xhi, ylo, yhi, sumx, sumy, den, wy, wxy, v;
		longint acc[4];
		logic [31:0] p;
		res = '0;
		sx = sc_x < 16 ? 16 : (sc_x > 4096 ? 4096 : sc_x);
		sy = sc_y < 16 ? 16 : (sc_y > 4096 ? 4096 : sc_y);
		w = img_w > MAX_WIDTH ? MAX_WIDTH : img_w;
		h = img_h > MAX_HEIGHT ? MAX_HEIGHT : img_h;
		if (col >= ((w * sx) >> 8) || row >= ((h * sy) >> 8)) begin
			res.status = STAT_RANGE;
			return res;
		end
		rx = rad_q8(sx);
		ry = rad_q8(sy);
		cx = ctr_q8(col, sx);
		cy = ctr_q8(row, sy);
		xlo = -fdiv256(-(cx - rx));
		xhi = fdiv256(cx + rx);
		ylo = -fdiv256(-(cy - ry));
		yhi = fdiv256(cy + ry);
		if (xlo < 0) xlo = 0;
		if (xhi > w - 1) xhi = w - 1;
		if (ylo < 0) ylo = 0;
		if (yhi > h - 1) yhi = h - 1;
		sumx = 0;
		sumy = 0;
		for (int c = 0; c < 4; c++) acc[c] = 0;
		for (longint i = xlo; i <= xhi; i++)
			sumx += tent_wt(i * 256 - cx, rx);
		for (longint j = ylo; j <= yhi; j++) begin
			wy = tent_wt(j * 256 - cy, ry);
			sumy += wy;
			for (longint i = xlo; i <= xhi; i++) begin
				wxy = wy * tent_wt(i * 256 - cx, rx);
				p = pix_mem.exists(int'(j * MAX_WIDTH + i)) ? pix_mem[int'(j * MAX_WIDTH + i)] : '0;
				for (int c = 0; c < 4; c++)
					acc[c] += wxy * longint'(p[8*c +: 8]);
			end
		end
		if (sumx == 0 || sumy == 0) begin
			res.status = STAT_ZERO;
			return res;
		end
		den = sumx * sumy;
		for (int c = 0; c < 4; c++) begin
			v = (acc[c] + den / 2) / den;
			if (v > 255) v = 255;
			case (c)
				0: res.red = v[7:0];
				1: res.green = v[7:0];
				2: res.blue = v[7:0];
				default: res.alpha = v[7:0];
			endcase
		end
		res.status = STAT_COMPUTED;
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		pix_result_t exp_w;
		if (!arst_n) begin
			sc_x <= SCALE_ONE;
			sc_y <= SCALE_ONE;
			img_w <= 9'd256;
			img_h <= 9'd256;
			errors = 0;
			n_results = 0;
			n_computed = 0;
		end else begin
			// results first: a result never belongs to the word taken this edge
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word st=%0d", $time, out_ch.status);
				end else begin
					exp_w = expected_q.pop_front();
					if (exp_w.status == STAT_COMPUTED) n_computed++;
					if (out_ch.status !== exp_w.status || out_ch.out_red !== exp_w.red ||
						out_ch.out_green !== exp_w.green || out_ch.out_blue !== exp_w.blue ||
						out_ch.out_alpha !== exp_w.alpha) begin
						errors++;
						$display("%0t: mismatch exp st=%0d rgba=%h %h %h %h got st=%0d rgba=%h %h %h %h",
							$time, exp_w.status, exp_w.red, exp_w.green, exp_w.blue,
							exp_w.alpha, out_ch.status, out_ch.out_red, out_ch.out_green,
							out_ch.out_blue, out_ch.out_alpha);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.opcode == OP_LOAD) begin
					if (in_ch.row < MAX_HEIGHT && in_ch.col < MAX_WIDTH)
						pix_mem[int'(in_ch.row) * MAX_WIDTH + int'(in_ch.col)] =
							{in_ch.in_alpha, in_ch.in_blue, in_ch.in_green, in_ch.in_red};
					exp_w = '0;
					exp_w.status = STAT_LOADED;
					expected_q.push_back(exp_w);
				end else
					expected_q.push_back(resample(in_ch.row, in_ch.col));
			end
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_SCALE_X: sc_x <= cfg.data;
					REG_SCALE_Y: sc_y <= cfg.data;
					REG_SRC_WIDTH: img_w <= cfg.data[8:0];
					default: img_h <= cfg.data[8:0];
				endcase
			end
		end
	end
endmodule

@@ tb/tb_tent_filter_image_resampler_core.sv @@
// ----------------------------------------------------------------------------
// tb_tent_filter_image_resampler_core
// Drives load and request words through several scale and size settings,
// with random idling on both sides; a checker module scores every result.
// ----------------------------------------------------------------------------
module tb_tent_filter_image_resampler_core;
	import tfir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   errors, pending, n_results, n_computed;

	// idle percentages, changed per phase
	int src_idle, snk_idle;
	bit hold_sink;      // long receiver hold-off
	int words_sent;

	// current image size known to stimulus, so requests read only loaded pixels
	int cur_w, cur_h, cur_sx, cur_sy;

	tfir_in_if  in_ch ();
	tfir_out_if out_ch ();
	tfir_cfg_if cfg ();

	tent_filter_image_resampler_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	tfir_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.errors(errors), .pending(pending), .n_results(n_results), .n_computed(n_computed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL tent_filter_image_resampler_core");
		$finish;
	end

	// receiver: random stalls, or held off completely while hold_sink is set
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= !hold_sink && ($urandom_range(99) >= snk_idle);
		end
	end

	// one word on the input channel, with random gaps before it
	task automatic send_word(logic op, logic [11:0] row, logic [11:0] col, logic [31:0] rgba);
		while ($urandom_range(99) < src_idle)
			@(negedge clk);
		in_ch.valid   = 1'b1;
		in_ch.opcode <= op;
		in_ch.row    <= row;
		in_ch.col    <= col;
		{in_ch.in_alpha, in_ch.in_blue, in_ch.in_green, in_ch.in_red} <= rgba;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
		words_sent++;
	endtask

	// let the block drain before touching registers
	task automatic wait_idle();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] val);
		cfg.valid  = 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic set_geometry(int sx, int sy, int w, int h);
		wait_idle();
		write_reg(REG_SCALE_X, sx[12:0]);
		write_reg(REG_SCALE_Y, sy[12:0]);
		write_reg(REG_SRC_WIDTH, w[12:0]);
		write_reg(REG_SRC_HEIGHT, h[12:0]);
		cur_sx = sx < 16 ? 16 : (sx > 4096 ? 4096 : sx);
		cur_sy = sy < 16 ? 16 : (sy > 4096 ? 4096 : sy);
		cur_w = w == 0 ? 0 : (w > 256 ? 256 : w);
		cur_h = h == 0 ? 0 : (h > 256 ? 256 : h);
	endtask

	// fill the source area with random pixels so no request reads an unwritten one
	task automatic fill_image(int w, int h);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				send_word(OP_LOAD, r[11:0], c[11:0], $urandom());
	endtask

	// random request: mostly inside the output image, sometimes past its edge
	task automatic random_request();
		int ow, oh;
		logic [11:0] r, c;
		ow = (cur_w * cur_sx) >> 8;
		oh = (cur_h * cur_sy) >> 8;
		if ($urandom_range(9) == 0 || ow == 0 || oh == 0) begin
			r = 12'($urandom());
			c = 12'($urandom());
		end else begin
			r = 12'($urandom_range(oh - 1));
			c = 12'($urandom_range(ow - 1));
		end
		send_word(OP_REQ, r, c, $urandom());
	endtask

	task automatic random_phase(int sx, int sy, int w, int h, int n);
		set_geometry(sx, sy, w, h);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(4) == 0)
				// reload a pixel in area, or one on a random row, mostly outside the store and ignored
				send_word(OP_LOAD, ($urandom_range(3) == 0) ? 12'($urandom()) : 12'($urandom_range(h - 1)),
					12'($urandom_range(w - 1)), $urandom());
			else
				random_request();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_LOAD;
		in_ch.row = '0;
		in_ch.col = '0;
		in_ch.in_red = '0;
		in_ch.in_green = '0;
		in_ch.in_blue = '0;
		in_ch.in_alpha = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_SCALE_X;
		cfg.data = '0;
		hold_sink = 1'b0;
		src_idle = 35;
		snk_idle = 45;
		words_sent = 0;
		cur_w = 256; cur_h = 256; cur_sx = 256; cur_sy = 256;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: small 8x8 image with corner extremes; 16x16 loaded for later phases
		set_geometry(256, 256, 8, 8);
		fill_image(16, 16);
		send_word(OP_LOAD, 12'd0, 12'd0, 32'hFFFF_FFFF);
		send_word(OP_LOAD, 12'd7, 12'd7, 32'h0000_0000);
		send_word(OP_LOAD, 12'hFFF, 12'hFFF, 32'hA5A5_5A5A);   // outside store, ignored
		send_word(OP_REQ, 12'd0, 12'd0, '0);
		send_word(OP_REQ, 12'd7, 12'd7, '0);
		send_word(OP_REQ, 12'd8, 12'd0, '0);                   // out of range
		send_word(OP_REQ, 12'hFFF, 12'hFFF, '0);
		// smallest scale: big radius, output size 0 on 8x8
		set_geometry(16, 16, 8, 8);
		send_word(OP_REQ, 12'd0, 12'd0, '0);
		// below minimum scale, clamped; 16 wide image gives 1 output pixel
		set_geometry(0, 16, 16, 16);
		send_word(OP_REQ, 12'd0, 12'd0, '0);
		// largest scale and above-max clamp
		set_geometry(4096, 8191, 2, 2);
		send_word(OP_REQ, 12'd31, 12'd31, '0);
		send_word(OP_REQ, 12'd0, 12'd0, '0);
		// zero size and oversize
		set_geometry(256, 256, 0, 0);
		send_word(OP_REQ, 12'd0, 12'd0, '0);
		set_geometry(256, 256, 511, 1);
		send_word(OP_REQ, 12'd0, 12'd5, '0);

		// random, sender idles more lightly
		random_phase(256, 256, 16, 16, 60);
		random_phase(200, 300, 16, 16, 60);

		// long receiver hold-off with the sender still pushing
		hold_sink = 1'b1;
		fork
			begin
				for (int i = 0; i < 8; i++)
					send_word(OP_LOAD, 12'($urandom_range(31)), 12'($urandom_range(31)), $urandom());
			end
			begin
				repeat (300) @(negedge clk);
				hold_sink = 1'b0;
			end
		join

		src_idle = 45;
		snk_idle = 35;
		random_phase(64, 1000, 16, 16, 40);
		random_phase(4096, 128, 5, 16, 40);
		// sender pauses until everything is back
		wait_idle();
		src_idle = 0;
		snk_idle = 0;
		random_phase(37, 512, 16, 16, 35);
		random_phase(256, 256, 16, 16, 35);

		wait_idle();
		repeat (50) @(negedge clk);
		$display("Sent %0d words; %0d results checked, %0d of them filtered pixels.",
			words_sent, n_results, n_computed);
		$display("Covered scale 1/16..16 with clamping, size 0 and oversize, off-image requests.");
		if (errors == 0)
			$display("PASS tent_filter_image_resampler_core");
		else
			$display("FAIL tent_filter_image_resampler_core");
		$finish;
	end
endmodule

@@ filelist.f @@
design/tfir_pkg.sv
design/tfir_in_if.sv
design/tfir_out_if.sv
design/tfir_cfg_if.sv
design/tfir_div.sv
design/tfir_dp.sv
design/tfir_ctrl.sv
design/tent_filter_image_resampler_core.sv
tb/tfir_tb_if.sv
tb/tfir_checker.sv
tb/tb_tent_filter_image_resampler_core.sv
